@@ hdl/rot_pkg.sv @@
// Shared types and constants for the repeating one-shot timer.
// Used by the interfaces, the bit-serial arithmetic unit, the divider and the top level.
`default_nettype none
package rot_pkg;

  localparam int TIME_W = 32;
  localparam int CNT_W = $clog2(TIME_W + 1);
  localparam int OP_W = 3;
  localparam int CFG_IDX_W = 1;

  localparam logic [TIME_W-1:0] PERIOD_RST = TIME_W'(1000000);

  localparam logic [OP_W-1:0] OP_TICK = 3'd0;
  localparam logic [OP_W-1:0] OP_PAUSE = 3'd1;
  localparam logic [OP_W-1:0] OP_UNPAUSE = 3'd2;
  localparam logic [OP_W-1:0] OP_RESET = 3'd3;
  localparam logic [OP_W-1:0] OP_SET = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT = 1'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_DIV,
    ST_TL,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic              fin;
    logic              carry;
    logic              sp_borrow;
    logic              ps_borrow;
    logic [TIME_W-1:0] sum;
    logic [TIME_W-1:0] diff;
  } ser_res_t;

  typedef struct packed {
    logic              fin;
    logic [TIME_W-1:0] quotient;
    logic [TIME_W-1:0] remainder;
  } div_res_t;

endpackage
`default_nettype wire

@@ hdl/rot_if.sv @@
// Valid/ready channel interfaces for the timer's command and result transactions.
// Depends on rot_pkg for the field widths.
`default_nettype none
interface rot_in_if;
  logic                         valid;
  logic                         ready;
  logic [rot_pkg::OP_W-1:0]     operation;
  logic [rot_pkg::TIME_W-1:0]   amount;

  modport source (output valid, output operation, output amount, input ready);
  modport sink (input valid, input operation, input amount, output ready);
endinterface

interface rot_out_if;
  logic                         valid;
  logic                         ready;
  logic                         done_flag;
  logic [rot_pkg::TIME_W-1:0]   finish_count;
  logic [rot_pkg::TIME_W-1:0]   elapsed_now;
  logic [rot_pkg::TIME_W-1:0]   time_left;
  logic                         paused_flag;

  modport source (output valid, output done_flag, output finish_count, output elapsed_now,
                  output time_left, output paused_flag, input ready);
  modport sink (input valid, input done_flag, input finish_count, input elapsed_now,
                input time_left, input paused_flag, output ready);
endinterface
`default_nettype wire

@@ hdl/rot_serial_unit.sv @@
// Bit-serial adder and dual subtractor: computes x + y, the borrow of (x + y) - p,
// and p - (x + y), one bit per cycle, least significant bit first. Depends on rot_pkg.
`default_nettype none
module rot_serial_unit (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [rot_pkg::TIME_W-1:0] x_in,
  input  wire logic [rot_pkg::TIME_W-1:0] y_in,
  input  wire logic [rot_pkg::TIME_W-1:0] p_in,
  output rot_pkg::ser_res_t               res
);

  logic [rot_pkg::TIME_W-1:0] x_r, y_r, p_r, sum_r, diff_r;
  logic                       carry_r, sp_borrow_r, ps_borrow_r, fin_r;
  logic [rot_pkg::CNT_W-1:0]  cnt_r;
  logic                       xb, yb, pb, sb, db, carry_nxt, sp_borrow_nxt, ps_borrow_nxt;

  always_comb begin
    xb = x_r[0];
    yb = y_r[0];
    pb = p_r[0];
    sb = xb ^ yb ^ carry_r;
    carry_nxt = (xb & yb) | (carry_r & (xb ^ yb));
    sp_borrow_nxt = (~sb & pb) | (~(sb ^ pb) & sp_borrow_r);
    db = pb ^ sb ^ ps_borrow_r;
    ps_borrow_nxt = (~pb & sb) | (~(pb ^ sb) & ps_borrow_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      fin_r <= 1'b0;
    end else if (start) begin
      cnt_r <= rot_pkg::CNT_W'(rot_pkg::TIME_W);
      fin_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - rot_pkg::CNT_W'(1);
      fin_r <= (cnt_r == rot_pkg::CNT_W'(1));
    end else begin
      fin_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= x_in;
      y_r <= y_in;
      p_r <= p_in;
      carry_r <= 1'b0;
      sp_borrow_r <= 1'b0;
      ps_borrow_r <= 1'b0;
    end else if (cnt_r != '0) begin
      x_r <= x_r >> 1;
      y_r <= y_r >> 1;
      p_r <= p_r >> 1;
      sum_r <= {sb, sum_r[rot_pkg::TIME_W-1:1]};
      diff_r <= {db, diff_r[rot_pkg::TIME_W-1:1]};
      carry_r <= carry_nxt;
      sp_borrow_r <= sp_borrow_nxt;
      ps_borrow_r <= ps_borrow_nxt;
    end
  end

  assign res.fin = fin_r;
  assign res.carry = carry_r;
  assign res.sp_borrow = sp_borrow_r;
  assign res.ps_borrow = ps_borrow_r;
  assign res.sum = sum_r;
  assign res.diff = diff_r;

endmodule
`default_nettype wire

@@ hdl/rot_divider.sv @@
// Restoring divider that shifts one quotient bit into its dividend register per cycle.
// Produces the truncated quotient and the true remainder. Depends on rot_pkg.
`default_nettype none
module rot_divider (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [rot_pkg::TIME_W-1:0] dividend,
  input  wire logic [rot_pkg::TIME_W-1:0] divisor,
  output rot_pkg::div_res_t               res
);

  logic [rot_pkg::TIME_W-1:0] rem_r, quo_r, dvs_r;
  logic [rot_pkg::CNT_W-1:0]  cnt_r;
  logic                       fin_r;
  logic [rot_pkg::TIME_W:0]   trial;
  logic [rot_pkg::TIME_W+1:0] sub;
  logic                       ge;

  always_comb begin
    trial = {rem_r, quo_r[rot_pkg::TIME_W-1]};
    sub = {1'b0, trial} - {2'b00, dvs_r};
    ge = ~sub[rot_pkg::TIME_W+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      fin_r <= 1'b0;
    end else if (start) begin
      cnt_r <= rot_pkg::CNT_W'(rot_pkg::TIME_W);
      fin_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - rot_pkg::CNT_W'(1);
      fin_r <= (cnt_r == rot_pkg::CNT_W'(1));
    end else begin
      fin_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (cnt_r != '0) begin
      rem_r <= ge ? sub[rot_pkg::TIME_W-1:0] : trial[rot_pkg::TIME_W-1:0];
      quo_r <= {quo_r[rot_pkg::TIME_W-2:0], ge};
    end
  end

  assign res.fin = fin_r;
  assign res.quotient = quo_r;
  assign res.remainder = rem_r;

endmodule
`default_nettype wire

@@ hdl/repeating_oneshot_timer.sv @@
// Top level of the repeating one-shot timer: command channel, result channel, config port.
// Depends on rot_pkg, rot_if, rot_serial_unit and rot_divider.
//
// Each command transaction on in_chan (tick, pause, unpause, reset, set elapsed) yields
// exactly one result transaction on out_chan carrying the timer state after the command.
// The user must write period and repeat mode via cfg_we/cfg_index/cfg_data only while the
// block is idle; the block does not enforce this. They apply from the next command on.
// Commands are processed one at a time. Every command makes one pass through the
// bit-serial add/subtract unit, and a new command is accepted only after the previous
// result has been loaded into the output register. A tick that wraps in repeating mode
// with a nonzero period runs the add pass, then the restoring divider, then a second
// subtract pass for the time left.
// The serial unit and the divider each work one bit per cycle.
// The result sits in an output register, so the next command is accepted while the
// previous result still waits; a stalled receiver blocks only when a newer result is ready.
// Synchronous reset clears the timer state and loads a period of 1000000 in once mode.
`default_nettype none
module repeating_oneshot_timer (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [rot_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rot_pkg::TIME_W-1:0]    cfg_data,
  rot_in_if.sink                             in_chan,
  rot_out_if.source                          out_chan
);

  rot_pkg::state_t            state_r, state_nxt;
  logic [rot_pkg::TIME_W-1:0] period_r;
  logic                       repeat_r;
  logic [rot_pkg::TIME_W-1:0] elapsed_r, elapsed_nxt, count_r, count_nxt, tl_r, tl_nxt;
  logic                       paused_r, paused_nxt, done_r, done_nxt;
  logic                       ser_start, div_start, out_load;
  logic [rot_pkg::TIME_W-1:0] ser_x, ser_y, sum_val;
  logic                       ge;
  logic                       out_valid_r, out_done_r, out_paused_r;
  logic [rot_pkg::TIME_W-1:0] out_count_r, out_elapsed_r, out_tl_r;
  rot_pkg::ser_res_t          ser_res;
  rot_pkg::div_res_t          div_res;

  rot_serial_unit u_serial (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ser_start),
    .x_in  (ser_x),
    .y_in  (ser_y),
    .p_in  (period_r),
    .res   (ser_res)
  );

  rot_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_val),
    .divisor  (period_r),
    .res      (div_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= rot_pkg::PERIOD_RST;
      repeat_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        rot_pkg::CFG_PERIOD: period_r <= cfg_data;
        rot_pkg::CFG_REPEAT: repeat_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rot_pkg::ST_IDLE;
      elapsed_r <= '0;
      count_r <= '0;
      paused_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      elapsed_r <= elapsed_nxt;
      count_r <= count_nxt;
      paused_r <= paused_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tl_r <= tl_nxt;
  end

  always_comb begin
    sum_val = ser_res.carry ? '1 : ser_res.sum;
    ge = ser_res.carry | ~ser_res.sp_borrow;
  end

  always_comb begin
    state_nxt = state_r;
    elapsed_nxt = elapsed_r;
    count_nxt = count_r;
    paused_nxt = paused_r;
    done_nxt = done_r;
    tl_nxt = tl_r;
    ser_start = 1'b0;
    ser_x = elapsed_r;
    ser_y = '0;
    div_start = 1'b0;
    out_load = 1'b0;
    case (state_r)
      rot_pkg::ST_IDLE: begin
        if (in_chan.valid) begin
          ser_start = 1'b1;
          state_nxt = rot_pkg::ST_TL;
          case (in_chan.operation)
            rot_pkg::OP_TICK: begin
              if (paused_r) begin
                count_nxt = '0;
                if (repeat_r) begin
                  done_nxt = 1'b0;
                end
              end else if (!repeat_r && done_r) begin
                count_nxt = '0;
              end else begin
                ser_y = in_chan.amount;
                state_nxt = rot_pkg::ST_ADD;
              end
            end
            rot_pkg::OP_PAUSE: paused_nxt = 1'b1;
            rot_pkg::OP_UNPAUSE: paused_nxt = 1'b0;
            rot_pkg::OP_RESET: begin
              elapsed_nxt = '0;
              done_nxt = 1'b0;
              count_nxt = '0;
              ser_x = '0;
            end
            rot_pkg::OP_SET: begin
              elapsed_nxt = in_chan.amount;
              ser_x = in_chan.amount;
            end
            default: ;
          endcase
        end
      end
      rot_pkg::ST_ADD: begin
        if (ser_res.fin) begin
          state_nxt = rot_pkg::ST_OUT;
          if (!ge) begin
            elapsed_nxt = ser_res.sum;
            done_nxt = 1'b0;
            count_nxt = '0;
            tl_nxt = ser_res.diff;
          end else if (!repeat_r) begin
            done_nxt = 1'b1;
            count_nxt = rot_pkg::TIME_W'(1);
            elapsed_nxt = period_r;
            tl_nxt = '0;
          end else if (period_r == '0) begin
            done_nxt = 1'b1;
            count_nxt = '1;
            elapsed_nxt = '0;
            tl_nxt = '0;
          end else begin
            done_nxt = 1'b1;
            div_start = 1'b1;
            state_nxt = rot_pkg::ST_DIV;
          end
        end
      end
      rot_pkg::ST_DIV: begin
        if (div_res.fin) begin
          count_nxt = div_res.quotient;
          elapsed_nxt = div_res.remainder;
          ser_start = 1'b1;
          ser_x = div_res.remainder;
          state_nxt = rot_pkg::ST_TL;
        end
      end
      rot_pkg::ST_TL: begin
        if (ser_res.fin) begin
          tl_nxt = ser_res.ps_borrow ? '0 : ser_res.diff;
          state_nxt = rot_pkg::ST_OUT;
        end
      end
      rot_pkg::ST_OUT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_load = 1'b1;
          state_nxt = rot_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rot_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_done_r <= done_r;
      out_count_r <= count_r;
      out_elapsed_r <= elapsed_r;
      out_tl_r <= tl_r;
      out_paused_r <= paused_r;
    end
  end

  assign in_chan.ready = (state_r == rot_pkg::ST_IDLE);
  assign out_chan.valid = out_valid_r;
  assign out_chan.done_flag = out_done_r;
  assign out_chan.finish_count = out_count_r;
  assign out_chan.elapsed_now = out_elapsed_r;
  assign out_chan.time_left = out_tl_r;
  assign out_chan.paused_flag = out_paused_r;

  a_ser_fin_state: assert property (@(posedge clk) disable iff (!rst_n)
    ser_res.fin |-> (state_r == rot_pkg::ST_ADD || state_r == rot_pkg::ST_TL))
    else $error("serial unit finished outside an arithmetic pass");

  a_div_fin_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.fin |-> (state_r == rot_pkg::ST_DIV))
    else $error("divider finished outside the division state");

  a_rem_below_period: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.fin |-> (div_res.remainder < period_r))
    else $error("remainder not below the period");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> (state_r != rot_pkg::ST_IDLE))
    else $error("accepted transaction left the controller idle");

endmodule
`default_nettype wire

@@ test/testbench.sv @@
// Self-checking testbench for repeating_oneshot_timer: a queue-fed driver, a monitor and an
// in-line timer predictor that checks every result transaction field by field.
// Depends on rot_pkg, the rot_in_if/rot_out_if interfaces and the timer top level.
module testbench;
  import rot_pkg::*;

  localparam logic [OP_W-1:0] OP_LAST = '1;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam int SETTLE_CYCLES = 120;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEMS_PER_SETTING = 113;
  localparam int HOLD_AT = 900;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [TIME_W-1:0] amount;
  } cmd_t;

  typedef struct packed {
    logic              done_flag;
    logic [TIME_W-1:0] finish_count;
    logic [TIME_W-1:0] elapsed_now;
    logic [TIME_W-1:0] time_left;
    logic              paused_flag;
  } timer_out_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TIME_W-1:0] cfg_data;

  rot_in_if in_if ();
  rot_out_if out_if ();

  repeating_oneshot_timer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  cmd_t pending_cmds[$];
  timer_out_t expected_results[$];

  logic [TIME_W-1:0] m_period;
  logic              m_repeat;
  logic [TIME_W-1:0] m_elapsed;
  logic              m_paused;
  logic              m_done;
  logic [TIME_W-1:0] m_count;

  int sent_count;
  int checked_count;
  int mismatch_count;
  int cycle_count;
  int setting_count;
  int hold_left;
  logic hold_used;
  int tx_wait;
  int tx_quiet;
  int rx_wait;
  int rx_quiet;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int draw_gap(ref int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      quiet = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 10);
  endfunction

  function automatic timer_out_t advance_timer(input cmd_t c);
    timer_out_t r;
    logic [TIME_W:0] sum;
    case (c.op)
      OP_TICK: begin
        if (m_paused) begin
          m_count = '0;
          if (m_repeat) m_done = 1'b0;
        end else if (!m_repeat && m_done) begin
          m_count = '0;
        end else begin
          sum = {1'b0, m_elapsed} + {1'b0, c.amount};
          m_elapsed = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
          m_done = m_elapsed >= m_period;
          if (!m_done) begin
            m_count = '0;
          end else if (!m_repeat) begin
            m_count = 1;
            m_elapsed = m_period;
          end else if (m_period == 0) begin
            m_count = TIME_MAX;
            m_elapsed = '0;
          end else begin
            m_count = m_elapsed / m_period;
            m_elapsed = m_elapsed % m_period;
          end
        end
      end
      OP_PAUSE: m_paused = 1'b1;
      OP_UNPAUSE: m_paused = 1'b0;
      OP_RESET: begin
        m_elapsed = '0;
        m_done = 1'b0;
        m_count = '0;
      end
      OP_SET: m_elapsed = c.amount;
      default: ;
    endcase
    r.done_flag = m_done;
    r.finish_count = m_count;
    r.elapsed_now = m_elapsed;
    r.time_left = (m_period > m_elapsed) ? m_period - m_elapsed : '0;
    r.paused_flag = m_paused;
    return r;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int unsigned pick;
    longint unsigned p;
    longint unsigned a;
    p = m_period;
    pick = $urandom_range(0, 99);
    if (pick < 62) c.op = OP_TICK;
    else if (pick < 70) c.op = OP_SET;
    else if (pick < 78) c.op = OP_RESET;
    else if (pick < 86) c.op = OP_PAUSE;
    else if (pick < 96) c.op = OP_UNPAUSE;
    else c.op = OP_W'($urandom_range(OP_SET + 1, OP_LAST));
    case ($urandom_range(0, 9))
      0: a = 0;
      1: a = TIME_MAX;
      2, 3: a = $urandom;
      4, 5: a = $urandom_range(0, p / 4);
      6, 7: a = (p >= 2) ? p - $urandom_range(0, 2) : $urandom_range(0, 2);
      default: a = p * $urandom_range(1, 5) + $urandom_range(0, 3);
    endcase
    c.amount = (a > TIME_MAX) ? TIME_MAX : a[TIME_W-1:0];
    return c;
  endfunction

  task automatic queue_cmd(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] amount);
    cmd_t c;
    c.op = op;
    c.amount = amount;
    pending_cmds.push_back(c);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_PERIOD) m_period = val;
    else m_repeat = val[0];
  endtask

  task automatic set_timer(input logic [TIME_W-1:0] period, input logic rep);
    write_reg(CFG_PERIOD, period);
    write_reg(CFG_REPEAT, {$urandom, rep} >> 0 & {{(TIME_W-1){1'b1}}, 1'b0} | rep);
    setting_count++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || in_if.valid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               expected_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (!hold_used && sent_count >= HOLD_AT && pending_cmds.size() >= 20) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin : driver
    logic offering;
    cmd_t cur;
    cmd_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      tx_wait = 0;
    end else begin
      offering = in_if.valid;
      if (in_if.valid && in_if.ready) begin
        cur.op = in_if.operation;
        cur.amount = in_if.amount;
        expected_results.push_back(advance_timer(cur));
        sent_count <= sent_count + 1;
        tx_wait = draw_gap(tx_quiet);
        offering = 1'b0;
      end
      if (!offering) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_if.valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          nxt = pending_cmds.pop_front();
          in_if.valid <= 1'b1;
          in_if.operation <= nxt.op;
          in_if.amount <= nxt.amount;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    timer_out_t got;
    timer_out_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got.done_flag = out_if.done_flag;
        got.finish_count = out_if.finish_count;
        got.elapsed_now = out_if.elapsed_now;
        got.time_left = out_if.time_left;
        got.paused_flag = out_if.paused_flag;
        checked_count++;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Unexpected result: done=%0b count=%0d elapsed=%0d left=%0d paused=%0b",
                     got.done_flag, got.finish_count, got.elapsed_now, got.time_left,
                     got.paused_flag);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("Result %0d expected: done=%0b count=%0d elapsed=%0d left=%0d paused=%0b",
                       checked_count, want.done_flag, want.finish_count, want.elapsed_now,
                       want.time_left, want.paused_flag);
              $display("Result %0d actual:   done=%0b count=%0d elapsed=%0d left=%0d paused=%0b",
                       checked_count, got.done_flag, got.finish_count, got.elapsed_now,
                       got.time_left, got.paused_flag);
            end
          end
        end
        rx_wait = draw_gap(rx_quiet);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_if.ready <= (rx_wait == 0) && (hold_left == 0);
    end
  end

  initial begin
    logic [TIME_W-1:0] periods[8];
    periods[0] = 1;
    periods[1] = 0;
    periods[2] = TIME_MAX;
    periods[3] = 3;
    periods[4] = 1000;
    periods[5] = PERIOD_RST;
    periods[6] = $urandom;
    periods[7] = 32'h8000_0000;
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_PERIOD;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.operation = OP_TICK;
    in_if.amount = '0;
    out_if.ready = 1'b0;
    sent_count = 0;
    checked_count = 0;
    mismatch_count = 0;
    cycle_count = 0;
    setting_count = 1;
    tx_quiet = 0;
    rx_quiet = 0;
    m_period = PERIOD_RST;
    m_repeat = 1'b0;
    m_elapsed = '0;
    m_paused = 1'b0;
    m_done = 1'b0;
    m_count = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Once mode at the reset period: finish, clamp, ignored ticks, saturation, pause.
    queue_cmd(OP_TICK, 0);
    queue_cmd(OP_TICK, PERIOD_RST - 1);
    queue_cmd(OP_TICK, 1);
    queue_cmd(OP_TICK, 5);
    queue_cmd(OP_SET, TIME_MAX);
    queue_cmd(OP_RESET, TIME_MAX);
    queue_cmd(OP_SET, TIME_MAX);
    queue_cmd(OP_TICK, TIME_MAX);
    queue_cmd(OP_PAUSE, 0);
    queue_cmd(OP_TICK, 3);
    queue_cmd(OP_UNPAUSE, 0);
    queue_cmd(OP_RESET, 0);
    queue_cmd(OP_SET + 1, TIME_MAX);
    queue_cmd(OP_LAST, 0);
    wait_idle();

    // Repeating mode: wrap counts, excess after set elapsed, paused tick clearing done.
    set_timer(7, 1'b1);
    queue_cmd(OP_TICK, 20);
    queue_cmd(OP_SET, 100);
    queue_cmd(OP_TICK, 0);
    queue_cmd(OP_PAUSE, 0);
    queue_cmd(OP_TICK, 3);
    queue_cmd(OP_UNPAUSE, 0);
    queue_cmd(OP_TICK, TIME_MAX);
    queue_cmd(OP_RESET, 0);
    wait_idle();

    // A zero period in repeating mode reports the maximum count.
    set_timer(0, 1'b1);
    queue_cmd(OP_TICK, 5);
    queue_cmd(OP_TICK, 0);
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      for (int r = 0; r < 2; r++) begin
        set_timer(periods[p], r[0]);
        for (int i = 0; i < ITEMS_PER_SETTING; i++) pending_cmds.push_back(random_cmd());
        wait_idle();
      end
    end

    if (expected_results.size() != 0) mismatch_count++;
    $display("Checked %0d results from %0d commands over %0d period and mode settings.",
             checked_count, sent_count, setting_count);
    $display("Receiver hold-off applied: %0b, mismatches: %0d", hold_used, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
